FILE: rtl/core/mcirc_pkg.sv
// Shared types and constants for the midpoint circle outline rasterizer.
// No dependencies; used by the front, queue, back and top level files.
package mcirc_pkg;

  localparam int unsigned CTR_W   = 15;  // center coordinate width, signed
  localparam int unsigned RAD_W   = 14;  // radius width, unsigned
  localparam int unsigned RUN_W   = 15;  // run_x / run_y width, unsigned
  localparam int unsigned DEC_W   = 18;  // decision term width, signed
  localparam int unsigned PIX_W   = 16;  // output pixel field width
  localparam int unsigned COLOR_W = 32;
  localparam int unsigned Q_DEPTH = 2;   // step queue entries

  localparam logic OP_START = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  localparam logic [31:0] COLOR_RESET = 32'hFFFF_FFFF;

  // One queued step: center and the pre-update offsets, plus finish flag.
  typedef struct packed {
    logic signed [CTR_W-1:0] cx;
    logic signed [CTR_W-1:0] cy;
    logic [RUN_W-1:0]        run_x;
    logic [RUN_W-1:0]        run_y;
    logic                    fin;
  } step_t;

  // Producer side of the step queue.
  typedef struct packed {
    logic  push;
    step_t data;
  } q_wr_t;

  // Consumer side of the step queue.
  typedef struct packed {
    logic  valid;
    step_t data;
  } q_rd_t;

endpackage

FILE: rtl/core/midpoint_circle_outline_top.sv
// Midpoint circle outline rasterizer, top level.
// Depends on mcirc_pkg, mcirc_front, mcirc_queue and mcirc_back.
//
// Input channel (in_*): a word with in_op = start loads center and radius and
// produces nothing; a word with in_op = step advances the outline one step and
// produces eight pixel words on the out_* channel, the eighth with out_last
// set and, if the outline is complete, out_done_res. Steps on an idle circle
// produce nothing. A start with radius zero leaves the circle idle.
// cfg_* writes the draw color, attached to every pixel; write it while idle.
// The first pixel of a step passes the step queue and then the back end's
// output register. Throughput: one pixel per cycle while out_ready is high,
// set by the back end's single output register. Two steps can queue between
// front and back, so starts and steps keep being accepted while pixels drain.
// When out_ready is low the output word holds and the queue fills; in_ready
// drops once it is full. Reset (rst_n low, synchronous) clears the circle
// state, empties the queue and sets the color to all ones. cfg_ready is 1.
module midpoint_circle_outline_top #(
  parameter int unsigned COORD_WIDTH = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 in_op,
  input  logic signed [mcirc_pkg::CTR_W-1:0]   in_center_x,
  input  logic signed [mcirc_pkg::CTR_W-1:0]   in_center_y,
  input  logic [mcirc_pkg::RAD_W-1:0]          in_radius,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [mcirc_pkg::PIX_W-1:0]   out_pixel_x,
  output logic signed [mcirc_pkg::PIX_W-1:0]   out_pixel_y,
  output logic [mcirc_pkg::COLOR_W-1:0]        out_color,
  output logic                                 out_last,
  output logic                                 out_done_res,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [mcirc_pkg::COLOR_W-1:0]        cfg_data
);

  logic [mcirc_pkg::COLOR_W-1:0] draw_color_r;
  mcirc_pkg::q_wr_t              q_wr;
  mcirc_pkg::q_rd_t              q_rd;
  logic                          q_full;
  logic                          q_pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      draw_color_r <= mcirc_pkg::COLOR_RESET;
    end else if (cfg_valid) begin
      draw_color_r <= cfg_data;
    end
  end

  mcirc_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_op       (in_op),
    .in_center_x (in_center_x),
    .in_center_y (in_center_y),
    .in_radius   (in_radius),
    .q_full      (q_full),
    .q_wr        (q_wr)
  );

  mcirc_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .q_wr  (q_wr),
    .full  (q_full),
    .q_rd  (q_rd),
    .pop   (q_pop)
  );

  mcirc_back #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_rd         (q_rd),
    .pop          (q_pop),
    .color        (draw_color_r),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_pixel_x  (out_pixel_x),
    .out_pixel_y  (out_pixel_y),
    .out_color    (out_color),
    .out_last     (out_last),
    .out_done_res (out_done_res)
  );

endmodule

FILE: rtl/core/mcirc_front.sv
// Front end: accepts start/step words, holds the circle state and runs the
// midpoint update, pushing one step_t per drawn step. Uses mcirc_pkg.
module mcirc_front (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  in_op,
  input  logic signed [mcirc_pkg::CTR_W-1:0]    in_center_x,
  input  logic signed [mcirc_pkg::CTR_W-1:0]    in_center_y,
  input  logic [mcirc_pkg::RAD_W-1:0]           in_radius,
  input  logic                                  q_full,
  output mcirc_pkg::q_wr_t                      q_wr
);

  logic signed [mcirc_pkg::CTR_W-1:0] origin_x_r, origin_x_nxt;
  logic signed [mcirc_pkg::CTR_W-1:0] origin_y_r, origin_y_nxt;
  logic [mcirc_pkg::RUN_W-1:0]        run_x_r, run_x_nxt;
  logic [mcirc_pkg::RUN_W-1:0]        run_y_r, run_y_nxt;
  logic signed [mcirc_pkg::DEC_W-1:0] decision_r, decision_nxt;
  logic                               busy_r, busy_nxt;

  logic                               accept;
  logic signed [mcirc_pkg::DEC_W-1:0] dec_add;
  logic [mcirc_pkg::RUN_W-1:0]        x_step, y_step;
  logic signed [mcirc_pkg::DEC_W-1:0] dec_step;
  logic                               fin;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    dec_add = decision_r + $signed({2'b00, run_y_r, 1'b0});
    y_step  = run_y_r + 1'b1;
    x_step  = run_x_r;
    dec_step = dec_add;
    if (!dec_add[mcirc_pkg::DEC_W-1]) begin
      x_step   = run_x_r - 1'b1;
      dec_step = dec_add - ($signed({2'b00, x_step, 1'b0}) - 18'sd1);
    end
    fin = x_step < y_step;
  end

  always_comb begin
    origin_x_nxt = origin_x_r;
    origin_y_nxt = origin_y_r;
    run_x_nxt    = run_x_r;
    run_y_nxt    = run_y_r;
    decision_nxt = decision_r;
    busy_nxt     = busy_r;
    if (accept) begin
      if (in_op == mcirc_pkg::OP_START) begin
        origin_x_nxt = in_center_x;
        origin_y_nxt = in_center_y;
        run_x_nxt    = {1'b0, in_radius};
        run_y_nxt    = mcirc_pkg::RUN_W'(1);
        decision_nxt = -$signed({4'b0000, in_radius});
        busy_nxt     = (in_radius != '0);
      end else if (busy_r) begin
        run_x_nxt    = x_step;
        run_y_nxt    = y_step;
        decision_nxt = dec_step;
        busy_nxt     = !fin;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r <= '0;
      origin_y_r <= '0;
      run_x_r    <= '0;
      run_y_r    <= '0;
      decision_r <= '0;
      busy_r     <= 1'b0;
    end else begin
      origin_x_r <= origin_x_nxt;
      origin_y_r <= origin_y_nxt;
      run_x_r    <= run_x_nxt;
      run_y_r    <= run_y_nxt;
      decision_r <= decision_nxt;
      busy_r     <= busy_nxt;
    end
  end

  assign q_wr.push       = accept && (in_op == mcirc_pkg::OP_STEP) && busy_r;
  assign q_wr.data.cx    = origin_x_r;
  assign q_wr.data.cy    = origin_y_r;
  assign q_wr.data.run_x = run_x_r;
  assign q_wr.data.run_y = run_y_r;
  assign q_wr.data.fin   = fin;

endmodule

FILE: rtl/core/mcirc_queue.sv
// Short step queue between front and back ends, register based.
// Depth from mcirc_pkg::Q_DEPTH; entry type mcirc_pkg::step_t.
module mcirc_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  mcirc_pkg::q_wr_t  q_wr,
  output logic              full,
  output mcirc_pkg::q_rd_t  q_rd,
  input  logic              pop
);

  localparam int unsigned PTR_W = (mcirc_pkg::Q_DEPTH > 1) ? $clog2(mcirc_pkg::Q_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(mcirc_pkg::Q_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(mcirc_pkg::Q_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(mcirc_pkg::Q_DEPTH);

  mcirc_pkg::step_t  mem_r [mcirc_pkg::Q_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;

  assign full       = (count_r == FULL_CNT);
  assign q_rd.valid = (count_r != '0);
  assign q_rd.data  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (q_wr.push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({q_wr.push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_wr.push) begin
      mem_r[wr_ptr_r] <= q_wr.data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_wr.push |-> !full) else $error("step queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> q_rd.valid) else $error("step queue popped while empty");

endmodule

FILE: rtl/core/mcirc_back.sv
// Back end: walks the eight octant pixels of the queued step into the output
// register, one per cycle unless stalled. Uses mcirc_pkg; fed by mcirc_queue.
module mcirc_back #(
  parameter int unsigned COORD_WIDTH = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  mcirc_pkg::q_rd_t                     q_rd,
  output logic                                 pop,
  input  logic [mcirc_pkg::COLOR_W-1:0]        color,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [mcirc_pkg::PIX_W-1:0]   out_pixel_x,
  output logic signed [mcirc_pkg::PIX_W-1:0]   out_pixel_y,
  output logic [mcirc_pkg::COLOR_W-1:0]        out_color,
  output logic                                 out_last,
  output logic                                 out_done_res
);

  localparam int unsigned SUM_W = 33;

  logic [2:0]                          pix_cnt_r, pix_cnt_nxt;
  logic                                out_valid_r;
  logic signed [mcirc_pkg::PIX_W-1:0]  pixel_x_r, pixel_y_r;
  logic [mcirc_pkg::COLOR_W-1:0]       color_r;
  logic                                last_r, done_r;

  logic                                load;
  logic signed [SUM_W-1:0]             xp, xm, yp, ym, off_x, off_y, sum_x, sum_y;
  logic signed [mcirc_pkg::PIX_W-1:0]  pix_x, pix_y;

  // wrap to COORD_WIDTH, then sign extend / truncate to the 16 bit field
  function automatic logic signed [mcirc_pkg::PIX_W-1:0] fit(input logic signed [SUM_W-1:0] s);
    logic [COORD_WIDTH-1:0]                     c;
    logic [COORD_WIDTH+mcirc_pkg::PIX_W-1:0]    e;
    c = s[COORD_WIDTH-1:0];
    e = {{mcirc_pkg::PIX_W{c[COORD_WIDTH-1]}}, c};
    return $signed(e[mcirc_pkg::PIX_W-1:0]);
  endfunction

  always_comb begin
    xp = $signed({18'd0, q_rd.data.run_x}) - 33'sd1;
    xm = -$signed({18'd0, q_rd.data.run_x});
    yp = $signed({18'd0, q_rd.data.run_y}) - 33'sd1;
    ym = -$signed({18'd0, q_rd.data.run_y});
    case (pix_cnt_r)
      3'd0:    begin off_x = xp; off_y = yp; end
      3'd1:    begin off_x = yp; off_y = xp; end
      3'd2:    begin off_x = xm; off_y = yp; end
      3'd3:    begin off_x = yp; off_y = xm; end
      3'd4:    begin off_x = xp; off_y = ym; end
      3'd5:    begin off_x = ym; off_y = xp; end
      3'd6:    begin off_x = xm; off_y = ym; end
      default: begin off_x = ym; off_y = xm; end
    endcase
    sum_x = SUM_W'(q_rd.data.cx) + off_x;
    sum_y = SUM_W'(q_rd.data.cy) + off_y;
    pix_x = fit(sum_x);
    pix_y = fit(sum_y);
  end

  assign load        = q_rd.valid && (!out_valid_r || out_ready);
  assign pop         = load && (pix_cnt_r == 3'd7);
  assign pix_cnt_nxt = load ? pix_cnt_r + 1'b1 : pix_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pix_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pix_cnt_r <= pix_cnt_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      pixel_x_r <= pix_x;
      pixel_y_r <= pix_y;
      color_r   <= color;
      last_r    <= (pix_cnt_r == 3'd7);
      done_r    <= (pix_cnt_r == 3'd7) && q_rd.data.fin;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_pixel_x  = pixel_x_r;
  assign out_pixel_y  = pixel_y_r;
  assign out_color    = color_r;
  assign out_last     = last_r;
  assign out_done_res = done_r;

  a_done_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && done_r |-> last_r) else $error("done without last");

  a_last_wraps: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> pix_cnt_r == 3'd0) else $error("pixel counter out of step with pop");

endmodule

FILE: dv/midpoint_circle_outline_top_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for midpoint_circle_outline_top: drives start and step words,
// predicts every pixel word of the outline and compares it on the output channel.
// Depends on mcirc_pkg and the midpoint_circle_outline_top RTL.
module midpoint_circle_outline_top_tb;

  localparam logic signed [mcirc_pkg::CTR_W-1:0] COORD_MIN = mcirc_pkg::CTR_W'(-16384);
  localparam logic signed [mcirc_pkg::CTR_W-1:0] COORD_MAX = mcirc_pkg::CTR_W'(16383);
  localparam logic [mcirc_pkg::RAD_W-1:0]        RAD_MAX   = 14'h3FFF;
  localparam int                                 SETTLE    = 12;  // cycles after the last pixel

  typedef enum logic [1:0] {RDY_ALWAYS, RDY_RANDOM, RDY_PATTERN} rdy_mode_t;

  typedef struct {
    logic signed [mcirc_pkg::PIX_W-1:0] x;
    logic signed [mcirc_pkg::PIX_W-1:0] y;
    logic [mcirc_pkg::COLOR_W-1:0]      color;
    logic                               last;
    logic                               done;
  } pixel_t;

  logic                                 clk = 1'b0;
  logic                                 rst_n = 1'b0;
  logic                                 in_valid = 1'b0;
  logic                                 in_ready;
  logic                                 in_op = mcirc_pkg::OP_START;
  logic signed [mcirc_pkg::CTR_W-1:0]   in_center_x = '0;
  logic signed [mcirc_pkg::CTR_W-1:0]   in_center_y = '0;
  logic [mcirc_pkg::RAD_W-1:0]          in_radius = '0;
  logic                                 out_valid;
  logic                                 out_ready = 1'b0;
  logic signed [mcirc_pkg::PIX_W-1:0]   out_pixel_x;
  logic signed [mcirc_pkg::PIX_W-1:0]   out_pixel_y;
  logic [mcirc_pkg::COLOR_W-1:0]        out_color;
  logic                                 out_last;
  logic                                 out_done_res;
  logic                                 cfg_valid = 1'b0;
  logic                                 cfg_ready;
  logic [mcirc_pkg::COLOR_W-1:0]        cfg_data = '0;

  // outline predictor state
  int                                   ctr_x = 0;
  int                                   ctr_y = 0;
  int                                   off_x = 0;
  int                                   off_y = 0;
  int                                   err_term = 0;
  bit                                   outline_busy = 1'b0;
  logic [mcirc_pkg::COLOR_W-1:0]        draw_color_q = mcirc_pkg::COLOR_RESET;
  pixel_t                               expected_pixels[$];

  int                                   mismatches = 0;
  bit                                   gaps_on = 1'b1;
  int                                   burst_left = 0;
  rdy_mode_t                            rdy_mode = RDY_RANDOM;
  int                                   hold_req = 0;
  int                                   hold_left = 0;
  int                                   pat_phase = 0;

  midpoint_circle_outline_top u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_op        (in_op),
    .in_center_x  (in_center_x),
    .in_center_y  (in_center_y),
    .in_radius    (in_radius),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_pixel_x  (out_pixel_x),
    .out_pixel_y  (out_pixel_y),
    .out_color    (out_color),
    .out_last     (out_last),
    .out_done_res (out_done_res),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic void queue_pixel(input int px, input int py, input bit is_last,
                                      input bit is_done);
    pixel_t p;
    p.x     = px[mcirc_pkg::PIX_W-1:0];
    p.y     = py[mcirc_pkg::PIX_W-1:0];
    p.color = draw_color_q;
    p.last  = is_last;
    p.done  = is_done;
    expected_pixels.push_back(p);
  endfunction

  // Advance the outline for one accepted word and queue the pixels it yields.
  function automatic void trace_outline(input logic op,
                                        input logic signed [mcirc_pkg::CTR_W-1:0] cx,
                                        input logic signed [mcirc_pkg::CTR_W-1:0] cy,
                                        input logic [mcirc_pkg::RAD_W-1:0] r);
    int xp, xm, yp, ym;
    bit fin;
    if (op == mcirc_pkg::OP_START) begin
      ctr_x        = cx;
      ctr_y        = cy;
      off_x        = r;
      off_y        = 1;
      err_term     = -off_x;
      outline_busy = (off_x >= off_y);
    end else if (outline_busy) begin
      xp = off_x - 1;
      xm = off_x;
      yp = off_y - 1;
      ym = off_y;
      err_term += 2 * off_y;
      off_y    += 1;
      if (err_term >= 0) begin
        off_x    -= 1;
        err_term -= 2 * off_x - 1;
      end
      fin = off_x < off_y;
      if (fin) outline_busy = 1'b0;
      queue_pixel(ctr_x + xp, ctr_y + yp, 1'b0, 1'b0);
      queue_pixel(ctr_x + yp, ctr_y + xp, 1'b0, 1'b0);
      queue_pixel(ctr_x - xm, ctr_y + yp, 1'b0, 1'b0);
      queue_pixel(ctr_x + yp, ctr_y - xm, 1'b0, 1'b0);
      queue_pixel(ctr_x + xp, ctr_y - ym, 1'b0, 1'b0);
      queue_pixel(ctr_x - ym, ctr_y + xp, 1'b0, 1'b0);
      queue_pixel(ctr_x - xm, ctr_y - ym, 1'b0, 1'b0);
      queue_pixel(ctr_x - ym, ctr_y - xm, 1'b1, fin);
    end
  endfunction

  task automatic send_word(input logic op, input logic signed [mcirc_pkg::CTR_W-1:0] cx,
                           input logic signed [mcirc_pkg::CTR_W-1:0] cy,
                           input logic [mcirc_pkg::RAD_W-1:0] r);
    int gap;
    if (gaps_on && burst_left == 0) begin
      burst_left = $urandom_range(1, 10);
      gap        = $urandom_range(1, 6);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    if (burst_left > 0) burst_left--;
    @(negedge clk);
    in_valid    <= 1'b1;
    in_op       <= op;
    in_center_x <= cx;
    in_center_y <= cy;
    in_radius   <= r;
    do @(posedge clk); while (!in_ready);
    trace_outline(op, cx, cy, r);
  endtask

  // step word with junk in the fields the block ignores
  task automatic step_word();
    send_word(mcirc_pkg::OP_STEP, mcirc_pkg::CTR_W'($urandom), mcirc_pkg::CTR_W'($urandom),
              mcirc_pkg::RAD_W'($urandom));
  endtask

  task automatic wait_idle();
    int guard;
    guard = 0;
    @(negedge clk);
    in_valid  <= 1'b0;
    burst_left = 0;
    while (expected_pixels.size() != 0 && guard < 50000) begin
      @(posedge clk);
      guard++;
    end
    // a trailing step may produce nothing; let the pipe settle anyway
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_color(input logic [mcirc_pkg::COLOR_W-1:0] value);
    wait_idle();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    draw_color_q = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // receiver: long hold-off on request, otherwise the current stall pattern
  always @(negedge clk) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      pat_phase = (pat_phase == 6) ? 0 : pat_phase + 1;
      case (rdy_mode)
        RDY_ALWAYS: out_ready <= 1'b1;
        RDY_RANDOM: out_ready <= ($urandom_range(0, 3) != 0);
        default:    out_ready <= (pat_phase > 2);
      endcase
    end
  end

  // sample at the rising edge, compare on the falling edge
  always begin
    pixel_t got, want;
    bit     take;
    @(posedge clk);
    take      = rst_n && out_valid && out_ready;
    got.x     = out_pixel_x;
    got.y     = out_pixel_y;
    got.color = out_color;
    got.last  = out_last;
    got.done  = out_done_res;
    @(negedge clk);
    if (take) begin
      if (expected_pixels.size() == 0) begin
        $error("unexpected pixel word x=%0d y=%0d", got.x, got.y);
        mismatches++;
      end else begin
        want = expected_pixels.pop_front();
        if (got.x !== want.x) begin
          $error("pixel_x expected %0d got %0d", want.x, got.x);
          mismatches++;
        end
        if (got.y !== want.y) begin
          $error("pixel_y expected %0d got %0d", want.y, got.y);
          mismatches++;
        end
        if (got.color !== want.color) begin
          $error("color expected %h got %h", want.color, got.color);
          mismatches++;
        end
        if (got.last !== want.last) begin
          $error("last expected %b got %b", want.last, got.last);
          mismatches++;
        end
        if (got.done !== want.done) begin
          $error("done_res expected %b got %b", want.done, got.done);
          mismatches++;
        end
      end
    end
  end

  task automatic test_special_cases();
    gaps_on  = 1'b1;
    rdy_mode = RDY_RANDOM;
    step_word();                                   // step with no circle
    send_word(mcirc_pkg::OP_START, COORD_MIN, COORD_MAX, '0); // zero radius stays idle
    step_word();
    send_word(mcirc_pkg::OP_START, COORD_MAX, COORD_MAX, 14'd1);
    step_word();
    step_word();                                   // outline already done
    send_word(mcirc_pkg::OP_START, COORD_MIN, COORD_MIN, RAD_MAX);
    repeat (3) step_word();
    send_word(mcirc_pkg::OP_START, 15'sd0, 15'sd0, 14'd3);    // abandons the big circle
    repeat (3) step_word();
    set_color(32'h0000_0000);
    send_word(mcirc_pkg::OP_START, COORD_MAX, COORD_MIN, RAD_MAX);
    repeat (2) step_word();
    send_word(mcirc_pkg::OP_START, 15'sd100, -15'sd100, 14'd2);
    repeat (2) step_word();
  endtask

  // hold the output long enough that the step queue fills and in_ready drops
  task automatic test_output_backpressure();
    wait_idle();
    gaps_on  = 1'b0;
    rdy_mode = RDY_ALWAYS;
    hold_req = 400;
    send_word(mcirc_pkg::OP_START, 15'sd37, -15'sd21, 14'd30);
    repeat (20) step_word();
    wait_idle();
  endtask

  task automatic run_outline_mix(input int n_items);
    int                          sent, pick, limit, n;
    logic [mcirc_pkg::RAD_W-1:0] r;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 10)      r = '0;
      else if (pick < 70) r = mcirc_pkg::RAD_W'($urandom_range(1, 24));
      else if (pick < 92) r = mcirc_pkg::RAD_W'($urandom_range(25, 120));
      else                r = mcirc_pkg::RAD_W'($urandom);
      send_word(mcirc_pkg::OP_START, mcirc_pkg::CTR_W'($urandom),
                mcirc_pkg::CTR_W'($urandom), r);
      sent++;
      // big circles are cut short by the next start
      limit = (r > 120 || $urandom_range(0, 4) == 0) ? $urandom_range(1, 6) : 100000;
      n = 0;
      while (outline_busy && n < limit && sent < n_items) begin
        step_word();
        n++;
        sent++;
      end
      if (sent < n_items && $urandom_range(0, 3) == 0) begin
        step_word();
        sent++;
      end
    end
  endtask

  task automatic test_random_outlines();
    set_color($urandom);
    gaps_on  = 1'b0;
    rdy_mode = RDY_ALWAYS;
    run_outline_mix(60);
    set_color(32'h0000_0000);
    gaps_on  = 1'b1;
    rdy_mode = RDY_RANDOM;
    run_outline_mix(70);
    set_color(32'hFFFF_FFFF);
    rdy_mode = RDY_PATTERN;
    run_outline_mix(70);
    set_color(32'h8000_0001);
    rdy_mode = RDY_RANDOM;
    run_outline_mix(65);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_special_cases();
    test_output_backpressure();
    test_random_outlines();
    wait_idle();
    if (expected_pixels.size() != 0) begin
      $error("%0d pixel words never arrived", expected_pixels.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
